// ----- rtl/text_console_writer_core_defines.svh -----
// Assertion macros shared by the console writer RTL.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
// Package for the text console writer: payload structs, state encoding, char codes.
// No dependencies; used by tcw_screen_ram and text_console_writer_core.
package tcw_pkg;

  localparam int unsigned DefRows = 25;
  localparam int unsigned DefCols = 80;

  typedef logic [15:0] cell_t;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] AttrReset = 8'h07;
  localparam cell_t      BlankReset = {AttrReset, CharSpace};
  localparam int unsigned TabStep  = 4;

  localparam logic ModePut  = 1'b0;
  localparam logic ModeRead = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] char_code;
    logic [10:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_position;
    logic        scrolled;
    logic [15:0] cell_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EMIT,
    ST_SCOPY,
    ST_SBLANK
  } state_e;

endpackage

// ----- rtl/tcw_screen_ram.sv -----
// Screen cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell type.
module tcw_screen_ram #(
  parameter  int unsigned Depth = tcw_pkg::DefRows * tcw_pkg::DefCols,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  tcw_pkg::cell_t     wdata_i,
  input  logic               re_i,
  input  logic [AddrW-1:0]   raddr_i,
  output tcw_pkg::cell_t     rdata_o
);

  tcw_pkg::cell_t mem [Depth];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/text_console_writer_core.sv -----
// Text console writer top level: cursor logic, scroll/clear sequencer, handshakes.
// Depends on tcw_pkg, tcw_screen_ram and text_console_writer_core_defines.svh.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------
//  in      | in  | in_valid_i/in_stall_o | tcw_pkg::in_item_t
//  out     | out | out_valid_o/out_stall_i| tcw_pkg::out_item_t
//  cfg     | in  | cfg_valid_i/cfg_ready_o| default attribute byte
//
// A put or read request is accepted in the idle state; its result is loaded into
// the output register from the emit state (reads take the registered RAM read data).
// A put that scrolls first runs a copy pass over the RAM read/write port pair,
// moving every row up by one, then blanks the last row with the default attribute.
// After reset a clearing pass writes blanks to every cell; no request is
// accepted meanwhile, configuration writes are taken at all times.
// A stalled output holds the result; the next request is still accepted and
// its result waits in the state machine until the output register frees up.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core #(
  parameter int unsigned Rows = tcw_pkg::DefRows,
  parameter int unsigned Cols = tcw_pkg::DefCols
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tcw_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tcw_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned Cells   = Rows * Cols;
  localparam int unsigned CopyLen = Cells - Cols;
  localparam int unsigned AW      = $clog2(Cells);
  // cursor may run up to three past the end after a tab
  localparam int unsigned CW      = $clog2(Cells + tcw_pkg::TabStep);
  localparam int unsigned ColW    = $clog2(Cols);
  localparam int unsigned ColW1   = ColW + 1;

  tcw_pkg::state_e state_q, state_d;

  logic [7:0]      attr_q;
  logic [CW-1:0]   cursor_q;
  logic [ColW-1:0] col_q;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            res_scrolled_q, res_read_q;
  logic            out_valid_q;
  tcw_pkg::out_item_t out_q;

  logic            in_fire, is_put, read_ok, out_free, out_load;

  // put evaluation
  logic [7:0]      attr_in, ch;
  tcw_pkg::cell_t  put_cell, blank_cell;
  logic [CW-1:0]   cur_adv, cur_fin;
  logic [ColW-1:0] col_adv;
  logic [ColW1-1:0] col_inc, col_tab;
  logic            put_we, put_scroll;
  logic [AW-1:0]   put_waddr;
  tcw_pkg::cell_t  put_wdata;

  // RAM port
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  tcw_pkg::cell_t  ram_wdata, ram_rdata;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign is_put      = (in_item_i.mode == tcw_pkg::ModePut);
  assign read_ok     = !is_put && (32'(in_item_i.read_index) < 32'(Cells));
  assign in_stall_o  = (state_q != tcw_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign blank_cell  = {attr_q, tcw_pkg::CharSpace};

  // Cursor rules; col_q tracks cursor mod Cols so no divider is needed.
  always_comb begin : put_eval
    attr_in   = in_item_i.char_code[15:8];
    ch        = in_item_i.char_code[7:0];
    put_cell  = {(attr_in == 8'h00) ? attr_q : attr_in, ch};
    col_inc   = ColW1'(col_q) + ColW1'(1);
    col_tab   = ColW1'(col_q) + ColW1'(tcw_pkg::TabStep);
    cur_adv   = cursor_q;
    col_adv   = col_q;
    put_we    = 1'b0;
    put_waddr = AW'(cursor_q);
    put_wdata = put_cell;
    case (ch)
      tcw_pkg::CharLf: begin
        cur_adv = cursor_q + CW'(Cols) - CW'(col_q);
        col_adv = '0;
      end
      tcw_pkg::CharCr: begin
        cur_adv = cursor_q - CW'(col_q);
        col_adv = '0;
      end
      tcw_pkg::CharTab: begin
        cur_adv = cursor_q + CW'(tcw_pkg::TabStep);
        col_adv = (col_tab >= ColW1'(Cols)) ? ColW'(col_tab - ColW1'(Cols))
                                            : ColW'(col_tab);
      end
      tcw_pkg::CharBs: begin
        if (cursor_q != '0) begin
          cur_adv   = cursor_q - CW'(1);
          col_adv   = (col_q == '0) ? ColW'(Cols - 1) : col_q - ColW'(1);
          put_we    = 1'b1;
          put_waddr = AW'(cursor_q - CW'(1));
          put_wdata = blank_cell;
        end
      end
      default: begin
        put_we  = (cursor_q < CW'(Cells));
        cur_adv = cursor_q + CW'(1);
        col_adv = (col_inc == ColW1'(Cols)) ? '0 : ColW'(col_inc);
      end
    endcase
    put_scroll = (cur_adv >= CW'(Cells));
    cur_fin    = put_scroll ? cur_adv - CW'(Cols) : cur_adv;
  end

  // Next state
  always_comb begin : fsm_next
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (cnt_q == AW'(Cells - 1)) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (is_put && put_scroll) ? tcw_pkg::ST_SCOPY : tcw_pkg::ST_EMIT;
        end
      end
      tcw_pkg::ST_EMIT: begin
        if (out_free) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCOPY: begin
        if (cnt_q == AW'(CopyLen)) state_d = tcw_pkg::ST_SBLANK;
      end
      tcw_pkg::ST_SBLANK: begin
        if (cnt_q == AW'(Cells - 1)) state_d = tcw_pkg::ST_EMIT;
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs: RAM port, sweep counter, output load
  always_comb begin : fsm_out
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = tcw_pkg::BlankReset;
        cnt_d     = (cnt_q == AW'(Cells - 1)) ? '0 : cnt_q + AW'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          ram_we    = is_put && put_we;
          ram_waddr = put_waddr;
          ram_wdata = put_wdata;
          ram_re    = read_ok;
          ram_raddr = AW'(in_item_i.read_index);
        end
      end
      tcw_pkg::ST_EMIT: begin
        out_load = out_free;
      end
      tcw_pkg::ST_SCOPY: begin
        // read row below at cnt, write previous read one row up at cnt-1
        ram_re    = (cnt_q < AW'(CopyLen));
        ram_raddr = cnt_q + AW'(Cols);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - AW'(1);
        ram_wdata = ram_rdata;
        cnt_d     = (cnt_q == AW'(CopyLen)) ? cnt_q : cnt_q + AW'(1);
      end
      tcw_pkg::ST_SBLANK: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell;
        cnt_d     = (cnt_q == AW'(Cells - 1)) ? '0 : cnt_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tcw_pkg::ST_CLEAR;
      cnt_q          <= '0;
      attr_q         <= tcw_pkg::AttrReset;
      cursor_q       <= '0;
      col_q          <= '0;
      res_scrolled_q <= 1'b0;
      res_read_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      if (in_fire) begin
        res_scrolled_q <= is_put && put_scroll;
        res_read_q     <= read_ok;
        if (is_put) begin
          cursor_q <= cur_fin;
          col_q    <= col_adv;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; cell data comes straight from the RAM read register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.cursor_position <= 11'(cursor_q);
      out_q.scrolled        <= res_scrolled_q;
      out_q.cell_value      <= res_read_q ? ram_rdata : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  tcw_screen_ram #(
    .Depth (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `TCW_ASSERT_NOW(a_cursor_in_range, state_q == tcw_pkg::ST_IDLE, cursor_q < CW'(Cells), "cursor out of range at rest")
  `TCW_ASSERT_NOW(a_col_in_range, 1'b1, ColW1'(col_q) < ColW1'(Cols), "column tracker out of range")
  `TCW_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_q != tcw_pkg::ST_IDLE, "accepted request left no work")
  `TCW_ASSERT_NOW(a_copy_done, state_q == tcw_pkg::ST_SCOPY && state_d == tcw_pkg::ST_SBLANK, cnt_q == AW'(CopyLen), "copy pass ended early")
  `TCW_ASSERT_NOW(a_idle_write, ram_we && state_q == tcw_pkg::ST_IDLE, in_fire && is_put, "RAM written while idle")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for text_console_writer_core: screen writes, control codes,
// scrolling, cell reads and the default attribute register, checked against a predictor.
// Depends on tcw_pkg and the text_console_writer_core RTL.
module tb;

  // Geometry follows the block's defaults.
  localparam int unsigned Rows        = tcw_pkg::DefRows;
  localparam int unsigned Cols        = tcw_pkg::DefCols;
  localparam int unsigned ScreenCells = Rows * Cols;
  localparam int unsigned MaxIndex    = 2047;   // top of the 11-bit read_index field
  // Idle wait, long enough for a scroll's copy and blanking passes to finish.
  localparam int unsigned SettleCycles  = ScreenCells + Cols + 16;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int unsigned WatchdogLimit = 20000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  tcw_pkg::in_item_t  in_item_i;
  logic       out_valid_o;
  logic       out_stall_i;
  tcw_pkg::out_item_t out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  text_console_writer_core #(
    .Rows(Rows),
    .Cols(Cols)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predicted console state: screen contents, cursor and default attribute.
  // Updated at the moment a request is accepted, so it always reflects every
  // request the block has taken so far.
  // ---------------------------------------------------------------------------
  logic [15:0] screen_model [ScreenCells];
  int unsigned cursor_model;
  logic [7:0]  attr_model;
  tcw_pkg::out_item_t pending_results [$];   // predicted results not yet seen on the output

  // Run statistics and knobs.
  int unsigned put_count;
  int unsigned read_count;
  int unsigned scroll_count;
  int unsigned attr_writes;
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;    // chance of a gap after each accepted request
  int unsigned rx_idle_pct;    // chance of stalling the output in a given cycle
  int unsigned rx_hold_req;    // set by a test to ask for a long output stall
  int unsigned rx_hold_left;
  int unsigned quiet_cycles;

  function automatic logic [15:0] blank_cell();
    return {attr_model, tcw_pkg::CharSpace};
  endfunction

  // Applies one request to the predicted state and returns the result it causes.
  function automatic tcw_pkg::out_item_t console_apply(input tcw_pkg::in_item_t req);
    tcw_pkg::out_item_t res;
    logic [15:0] code;
    int unsigned i;
    res = '0;
    if (req.mode == tcw_pkg::ModeRead) begin
      // Out-of-range reads return zero; state is untouched.
      if (req.read_index < ScreenCells) res.cell_value = screen_model[req.read_index];
    end else begin
      code = req.char_code;
      if (code[15:8] == 8'h00) code[15:8] = attr_model;
      case (code[7:0])
        tcw_pkg::CharLf:  cursor_model += Cols - (cursor_model % Cols);
        tcw_pkg::CharCr:  cursor_model -= cursor_model % Cols;
        tcw_pkg::CharTab: cursor_model += tcw_pkg::TabStep;
        tcw_pkg::CharBs: begin
          // Backspace at cell zero does nothing.
          if (cursor_model > 0) begin
            cursor_model--;
            screen_model[cursor_model] = blank_cell();
          end
        end
        default: begin
          if (cursor_model < ScreenCells) screen_model[cursor_model] = code;
          cursor_model++;
        end
      endcase
      // Reaching the end (a tab may overshoot by up to 3) scrolls one row.
      if (cursor_model >= ScreenCells) begin
        for (i = 0; i < ScreenCells - Cols; i++) screen_model[i] = screen_model[i + Cols];
        for (i = ScreenCells - Cols; i < ScreenCells; i++) screen_model[i] = blank_cell();
        cursor_model -= Cols;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_position = 11'(cursor_model);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  function automatic tcw_pkg::in_item_t put_code(input logic [15:0] code);
    tcw_pkg::in_item_t req;
    req.mode       = tcw_pkg::ModePut;
    req.char_code  = code;
    req.read_index = 11'($urandom_range(MaxIndex));   // ignored for puts
    return req;
  endfunction

  function automatic tcw_pkg::in_item_t read_cell(input int unsigned idx);
    tcw_pkg::in_item_t req;
    req.mode       = tcw_pkg::ModeRead;
    req.char_code  = 16'($urandom_range(16'hFFFF));   // ignored for reads
    req.read_index = 11'(idx);
    return req;
  endfunction

  // Half the characters rely on the default attribute, half carry their own.
  function automatic logic [7:0] pick_attr();
    return ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255));
  endfunction

  // Mostly on-screen cells, sometimes past the end of the screen.
  function automatic int unsigned pick_read_index();
    return ($urandom_range(99) < 85) ? $urandom_range(ScreenCells - 1)
                                     : $urandom_range(MaxIndex, ScreenCells);
  endfunction

  // One step of a line of text: mostly printable characters, with tabs,
  // backspaces, carriage returns and reads mixed in. Near the end of the
  // screen tabs are favored so the overshoot-then-scroll case comes up often.
  function automatic tcw_pkg::in_item_t text_step();
    int unsigned roll;
    roll = $urandom_range(99);
    if (cursor_model >= ScreenCells - 4 && roll < 50)
      return put_code({pick_attr(), tcw_pkg::CharTab});
    if (roll < 15) return read_cell(pick_read_index());
    if (roll < 23) return put_code({pick_attr(), tcw_pkg::CharTab});
    if (roll < 28) return put_code({pick_attr(), tcw_pkg::CharBs});
    if (roll < 30) return put_code({pick_attr(), tcw_pkg::CharCr});
    return put_code({pick_attr(), 8'($urandom_range(8'h7E, 8'h20))});
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Offers one request and holds it until accepted. Valid is left high when
  // no gap follows, so back-to-back requests keep valid asserted.
  task automatic send_request(input tcw_pkg::in_item_t req);
    tcw_pkg::out_item_t res;
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    res = console_apply(req);
    pending_results.push_back(res);
    if (req.mode == tcw_pkg::ModeRead) read_count++;
    else put_count++;
    if (res.scrolled) scroll_count++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // Stops offering requests and waits until every predicted result has come
  // back, then waits out SettleCycles so the block is idle.
  task automatic wait_screen_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes the default attribute; only called with the block idle.
  task automatic write_attribute(input logic [7:0] attr);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= attr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    attr_model = attr;
    attr_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Screen after the clearing pass: blanks with the reset attribute, and
  // zero for reads past the end.
  task automatic test_reset_screen();
    send_request(read_cell(0));
    send_request(read_cell(ScreenCells - 1));
    send_request(read_cell(ScreenCells));
    send_request(read_cell(MaxIndex));
  endtask

  // Every control code, plain and attributed characters, field extremes.
  task automatic test_control_codes();
    send_request(put_code({8'h00, tcw_pkg::CharBs}));   // backspace at cell zero: no change
    send_request(put_code(16'h0041));                   // picks up the default attribute
    send_request(put_code(16'hFFFF));
    send_request(put_code(16'h0000));                   // NUL is stored like any character
    send_request(put_code(16'h1E42));
    send_request(put_code({8'h80, tcw_pkg::CharTab}));
    send_request(put_code({8'h00, tcw_pkg::CharBs}));   // blanks the cell it steps back onto
    send_request(put_code({8'h00, tcw_pkg::CharCr}));
    send_request(put_code({8'h00, tcw_pkg::CharLf}));
    send_request(put_code({8'h2D, tcw_pkg::CharLf}));
    send_request(put_code({8'h55, tcw_pkg::CharCr}));
    send_request(read_cell(0));
    send_request(read_cell(2));
    send_request(read_cell(7));
  endtask

  // A new attribute applies to later writes and blanks, not to cells already shown.
  task automatic test_attribute_change();
    wait_screen_idle();
    write_attribute(8'h00);
    send_request(read_cell(1));
    send_request(read_cell(ScreenCells - 1));
    send_request(put_code(16'h0043));
    send_request(put_code({8'h00, tcw_pkg::CharBs}));
    send_request(read_cell(cursor_model));
  endtask

  // Random text: lines of characters ending in a newline, with reads and
  // arbitrary 16-bit noise in between.
  task automatic test_random_text(input int unsigned n_items);
    int unsigned sent;
    int unsigned line_len;
    int unsigned roll;
    tcw_pkg::in_item_t noise;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_request(read_cell(pick_read_index()));
        sent++;
      end else if (roll < 22) begin
        noise.mode       = 1'($urandom_range(1));
        noise.char_code  = 16'($urandom_range(16'hFFFF));
        noise.read_index = 11'($urandom_range(MaxIndex));
        send_request(noise);
        sent++;
      end else begin
        // Mostly short lines; now and then one long enough to wrap.
        line_len = ($urandom_range(9) == 0) ? $urandom_range(100, 60) : $urandom_range(25);
        repeat (line_len) begin
          send_request(text_step());
          sent++;
        end
        if ($urandom_range(3) == 0) begin
          send_request(put_code({pick_attr(), tcw_pkg::CharCr}));
          sent++;
        end
        send_request(put_code({pick_attr(), tcw_pkg::CharLf}));
        sent++;
      end
    end
  endtask

  // Output held off for a long stretch while requests keep coming: the block
  // fills and must stall its input without losing or reordering anything.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_hold_req = 400;
    test_random_text(40);
    tx_idle_pct = 17;
    wait_screen_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_item_i      = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    tx_idle_pct    = 17;
    rx_idle_pct    = 17;
    rx_hold_req    = 0;
    put_count      = 0;
    read_count     = 0;
    scroll_count   = 0;
    attr_writes    = 0;
    mismatch_count = 0;
    attr_model     = tcw_pkg::AttrReset;
    cursor_model   = 0;
    foreach (screen_model[i]) screen_model[i] = tcw_pkg::BlankReset;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part; the first request also waits out the clearing pass.
    test_reset_screen();
    test_control_codes();
    test_attribute_change();

    test_random_text(300);

    // Full-rate stretch with the brightest attribute and no idling on either side.
    wait_screen_idle();
    write_attribute(8'hFF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_text(250);
    tx_idle_pct = 17;
    rx_idle_pct = 17;

    test_output_backpressure();

    write_attribute(8'($urandom_range(255)));
    test_random_text(280);

    wait_screen_idle();
    write_attribute(8'h00);
    test_random_text(250);

    wait_screen_idle();
    $display("Covered %0d requests: %0d puts, %0d reads, %0d scrolls, %0d attribute writes.",
             put_count + read_count, put_count, read_count, scroll_count, attr_writes);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus a long hold when a test asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_req - 1;
      rx_hold_req = 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic check_field(input string field, input logic [15:0] want, got);
    if (want !== got) begin
      mismatch_count++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endtask

  // Every accepted result is compared against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    tcw_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_position", 16'(want.cursor_position),
                    16'(out_item_o.cursor_position));
        check_field("scrolled", 16'(want.scrolled), 16'(out_item_o.scrolled));
        check_field("cell_value", want.cell_value, out_item_o.cell_value);
      end
    end
  end

  // Hang detection: any handshake on any channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule
